[rtl/sha_pkg.sv]
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out_req;

    typedef struct packed {
        logic       init_chain;
        logic       wr_byte;
        logic [7:0] wr_data;
        logic       start;
        logic       out_load;
        logic       out_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dp_sts;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_datapath.sv]
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic [31:0] o_word
);

    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_out [8];
    logic [1:0]  r_fill;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_cur, w_new, t1, t2, s0, s1, b0, b1, ch, mj;

    always_comb begin
        w_cur = r_w[0];
        s0 = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        b1 = ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + b1 + ch + ROUND_K[r_round] + w_cur;
        b0 = ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = b0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_round <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
        end else begin
            r_done <= 1'b0;
            if (i_cmd.init_chain) begin
                for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
                r_fill <= '0;
            end
            if (i_cmd.wr_byte) begin
                if (r_fill == 2'd0) begin
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k + 1];
                end
                r_w[15] <= {r_w[15][23:0], i_cmd.wr_data};
                r_fill <= r_fill + 2'd1;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
            end else if (r_busy) begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k + 1];
                r_w[15] <= w_new;
                r_v[0] <= t1 + t2;
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + t1;
                r_v[5] <= r_v[4];
                r_v[6] <= r_v[5];
                r_v[7] <= r_v[6];
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_done) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int k = 0; k < 8; k++) r_out[k] <= r_h[k];
        end else if (i_cmd.out_shift) begin
            for (int k = 0; k < 7; k++) r_out[k] <= r_out[k + 1];
            r_out[7] <= r_out[7];
        end
    end

    assign o_sts.busy = r_busy | r_done;
    assign o_sts.done = r_done;
    assign o_word     = r_out[0];

endmodule

[rtl/sha_ctrl.sv]
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_in_req i_req,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_valid,
    output logic    o_last,
    input  logic    i_stall
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_COMP  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic        r_close, n_close;
    logic        r_padded, n_padded;
    logic        r_lenw, n_lenw;
    logic [2:0]  r_oidx, n_oidx;
    logic [63:0] bits;
    logic [7:0]  pad_byte;
    logic        acc;

    assign bits = {r_count, 3'b000};
    assign acc  = i_valid && !o_stall;

    always_comb begin
        if (r_lenw)
            pad_byte = bits[8 * (7 - 32'(r_fill[2:0])) +: 8];
        else if (!r_padded)
            pad_byte = PAD_BYTE;
        else
            pad_byte = 8'h00;
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_count  = r_count;
        n_close  = r_close;
        n_padded = r_padded;
        n_lenw   = r_lenw;
        n_oidx   = r_oidx;
        o_cmd    = '0;
        o_stall  = (r_state != S_IDLE);
        o_valid  = (r_state == S_OUT);
        o_last   = (r_oidx == 3'd7);
        case (r_state)
            S_IDLE: begin
                if (acc && (i_req.byte_valid || i_req.end_of_message)) begin
                    n_close = i_req.end_of_message;
                    if (i_req.byte_valid) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.wr_data = i_req.data_byte;
                        n_count = r_count + 61'd1;
                        n_fill  = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            n_state = S_COMP;
                        end else if (i_req.end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                o_cmd.start = 1'b1;
                n_state = S_WAIT;
            end
            S_PAD: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_data = pad_byte;
                n_padded = 1'b1;
                n_fill = r_fill + 6'd1;
                if (r_fill == LEN_START - 6'd1) n_lenw = 1'b1;
                if (r_fill == 6'd63) n_state = S_COMP;
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    if (!r_close) n_state = S_IDLE;
                    else if (r_lenw) n_state = S_LOAD;
                    else n_state = S_PAD;
                end
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_oidx = 3'd0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    o_cmd.out_shift = 1'b1;
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        o_cmd.init_chain = 1'b1;
                        n_count  = '0;
                        n_close  = 1'b0;
                        n_padded = 1'b0;
                        n_lenw   = 1'b0;
                        n_fill   = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_count  <= '0;
            r_close  <= 1'b0;
            r_padded <= 1'b0;
            r_oidx   <= '0;
            r_lenw   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_close  <= n_close;
            r_padded <= n_padded;
            r_oidx   <= n_oidx;
            r_lenw   <= n_lenw;
        end
    end

endmodule

[rtl/sha256_stream_hasher_unit.sv]
// Input: a byte that completes no block is taken while the unit is idle; the byte that completes a
// block holds the input through start, 64 rounds one per cycle, and fold-back.
// End of message: padding bytes one per cycle, one or two blocks, a load step, 8 words.
// No new byte is taken until the compression of a completed block is done.
// Reset: synchronous, active low; loads the initial hash values, clears counters.
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_req
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] word;
    logic        last;

    sha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_valid (o_valid),
        .o_last  (last),
        .i_stall (i_stall)
    );

    sha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_word  (word)
    );

    assign o_req.digest_word = word;
    assign o_req.digest_last = last;

endmodule
